>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the histogram checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

>>> rtl/core/grh_pkg.sv
// ----------------------------------------------------------------------------
// grh_pkg
// Types and constants for the growing-range histogram.
// ----------------------------------------------------------------------------
package grh_pkg;

  localparam int DEPTH    = 256;
  localparam int COUNT_W  = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int SPAN_W   = $clog2(DEPTH) + 1;
  localparam int VALUE_W  = 32;
  localparam int DIFF_W   = VALUE_W + 1;
  localparam int GROUP    = 16;
  localparam int NGROUP   = DEPTH / GROUP;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_BUMP  = 2'd1,
    CELL_SHIFT = 2'd2,
    CELL_CLEAR = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  idx;
  } cell_cmd_t;

endpackage

>>> rtl/core/growing_range_histogram_top.sv
// Sequencing: a clear, the unused code or a refused add goes straight to the result beat; a query
//   inside the window reads its bin through the two-level registered read tree; an add first moves
//   the cell row one step per entry of downward window growth, then bumps and reads its bin.
// The block takes one beat at a time: input closes until the result beat is issued, and a
//   stalled result beat holds the next one back.
// Reset: synchronous, clears all bins and the window; no clearing pass.
// ----------------------------------------------------------------------------
// growing_range_histogram_top
// Histogram over a window of signed values that grows to take in each add that fits in 256 bins.
// ----------------------------------------------------------------------------
module growing_range_histogram_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action [1:0], value [33:2], zero pad [39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // count [15:0]
  output logic        m_tuser    // refused [0]
);
  import grh_pkg::*;

  cell_cmd_t          cmd;
  logic [COUNT_W-1:0] counts [DEPTH];
  logic [COUNT_W-1:0] taps   [DEPTH];
  logic [COUNT_W-1:0] gather_or;

  grh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (s_tdata[1:0]),
    .in_value    (s_tdata[33:2]),
    .gather_or   (gather_or),
    .cmd         (cmd),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_count   (m_tdata),
    .out_refused (m_tuser)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [COUNT_W-1:0] prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = counts[k-1];
    end
    grh_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .my_idx     (IDX_W'(k)),
      .cmd        (cmd),
      .prev_count (prev),
      .count      (counts[k]),
      .tap        (taps[k])
    );
  end

  grh_gather u_gather (
    .clk    (clk),
    .taps   (taps),
    .result (gather_or)
  );

endmodule

>>> rtl/core/grh_cell.sv
// ----------------------------------------------------------------------------
// grh_cell
// One histogram bin: holds a count, bumps it when addressed, takes its lower
// neighbour's count on a shift, and shows it on the read tap when addressed.
// ----------------------------------------------------------------------------
module grh_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [grh_pkg::IDX_W-1:0]    my_idx,
  input  grh_pkg::cell_cmd_t           cmd,
  input  logic [grh_pkg::COUNT_W-1:0]  prev_count,
  output logic [grh_pkg::COUNT_W-1:0]  count,
  output logic [grh_pkg::COUNT_W-1:0]  tap
);
  import grh_pkg::*;

  logic hit;

  assign hit = (my_idx == cmd.idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.op)
        CELL_BUMP: begin
          if (hit && (count != '1)) begin
            count <= count + COUNT_W'(1);
          end
        end
        CELL_SHIFT: count <= prev_count;
        CELL_CLEAR: count <= '0;
        default:    count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tap <= hit ? count : '0;
  end

endmodule

>>> rtl/core/grh_gather.sv
// ----------------------------------------------------------------------------
// grh_gather
// Registered OR tree over the cell taps; only the addressed cell is non-zero.
// ----------------------------------------------------------------------------
module grh_gather (
  input  logic                         clk,
  input  logic [grh_pkg::COUNT_W-1:0]  taps [grh_pkg::DEPTH],
  output logic [grh_pkg::COUNT_W-1:0]  result
);
  import grh_pkg::*;

  logic [COUNT_W-1:0] group_or [NGROUP];
  logic [COUNT_W-1:0] group_next [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        group_next[g] = group_next[g] | taps[g*GROUP + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    group_or <= group_next;
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NGROUP; g++) begin
      result = result | group_or[g];
    end
  end

endmodule

>>> rtl/core/grh_ctrl.sv
// ----------------------------------------------------------------------------
// grh_ctrl
// Sequencer: window bookkeeping, cell commands, result register.
// ----------------------------------------------------------------------------
module grh_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_action,
  input  logic [grh_pkg::VALUE_W-1:0]  in_value,
  input  logic [grh_pkg::COUNT_W-1:0]  gather_or,
  output grh_pkg::cell_cmd_t           cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [grh_pkg::COUNT_W-1:0]  out_count,
  output logic                         out_refused
);
  import grh_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CALC   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_BUMP   = 7'b0010000,
    ST_GATHER = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t              state;
  action_t             action;
  logic [VALUE_W-1:0]  value;
  logic [VALUE_W-1:0]  base;
  logic [SPAN_W-1:0]   span;
  logic [DIFF_W-1:0]   diff_hi;
  logic [DIFF_W-1:0]   diff_lo;
  logic [DIFF_W-1:0]   lo_room;
  logic [DIFF_W-1:0]   span_x;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    shift_cnt;
  logic [1:0]          gcnt;
  logic [COUNT_W-1:0]  res_count;
  logic                res_refused;
  logic                below;

  assign in_ready = (state == ST_IDLE);
  assign span_x   = DIFF_W'(span);
  assign lo_room  = DIFF_W'(DEPTH) - span_x;
  assign below    = diff_hi[DIFF_W-1];

  always_comb begin
    cmd.idx = idx;
    case (state)
      ST_SHIFT:  cmd.op = CELL_SHIFT;
      ST_BUMP:   cmd.op = CELL_BUMP;
      ST_DECIDE: cmd.op = (action == ACT_CLEAR) ? CELL_CLEAR : CELL_HOLD;
      default:   cmd.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      action      <= ACT_NONE;
      base        <= '0;
      span        <= '0;
      idx         <= '0;
      shift_cnt   <= '0;
      gcnt        <= '0;
      out_valid   <= 1'b0;
      res_refused <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            action <= action_t'(in_action);
            value  <= in_value;
            state  <= ST_CALC;
          end
        end
        ST_CALC: begin
          diff_hi <= {value[VALUE_W-1], value} - {base[VALUE_W-1], base};
          diff_lo <= {base[VALUE_W-1], base} - {value[VALUE_W-1], value};
          state   <= ST_DECIDE;
        end
        ST_DECIDE: begin
          res_refused <= 1'b0;
          res_count   <= '0;
          gcnt        <= '0;
          case (action)
            ACT_ADD: begin
              if (span == '0) begin
                base  <= value;
                span  <= SPAN_W'(1);
                idx   <= '0;
                state <= ST_BUMP;
              end else if (below) begin
                if (diff_lo > lo_room) begin
                  res_refused <= 1'b1;
                  state       <= ST_DONE;
                end else begin
                  base      <= value;
                  span      <= span + diff_lo[SPAN_W-1:0];
                  shift_cnt <= diff_lo[IDX_W-1:0];
                  idx       <= '0;
                  state     <= ST_SHIFT;
                end
              end else if (diff_hi >= span_x) begin
                if (diff_hi > DIFF_W'(DEPTH - 1)) begin
                  res_refused <= 1'b1;
                  state       <= ST_DONE;
                end else begin
                  span  <= diff_hi[SPAN_W-1:0] + SPAN_W'(1);
                  idx   <= diff_hi[IDX_W-1:0];
                  state <= ST_BUMP;
                end
              end else begin
                idx   <= diff_hi[IDX_W-1:0];
                state <= ST_BUMP;
              end
            end
            ACT_QUERY: begin
              if ((span != '0) && !below && (diff_hi < span_x)) begin
                idx   <= diff_hi[IDX_W-1:0];
                state <= ST_GATHER;
              end else begin
                state <= ST_DONE;
              end
            end
            ACT_CLEAR: begin
              base  <= '0;
              span  <= '0;
              state <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_SHIFT: begin
          shift_cnt <= shift_cnt - IDX_W'(1);
          if (shift_cnt == IDX_W'(1)) begin
            state <= ST_BUMP;
          end
        end
        ST_BUMP: begin
          gcnt  <= '0;
          state <= ST_GATHER;
        end
        ST_GATHER: begin
          gcnt <= gcnt + 2'd1;
          if (gcnt == 2'd2) begin
            res_count <= gather_or;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_count   <= res_count;
            out_refused <= res_refused;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/grh_checker.sv
// ----------------------------------------------------------------------------
// grh_checker
// Port-level checks on the histogram, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // a refused add carries no count
  `ASSERT_SAME(a_refused_zero, clk, rst, m_tvalid && m_tuser, m_tdata == 16'd0)

  // one beat in flight: input closes after each accepted beat
  `ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)

  // stalled result beat holds
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

endmodule

bind growing_range_histogram_top grh_checker u_grh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
